/* hw/rtl/s2h_pkg.sv */
package s2h_pkg;

    // Rounding direction codes held in the rounding mode register
    typedef enum logic [1:0] {
        RND_NEAREST_EVEN = 2'd0,
        RND_DOWN         = 2'd1,
        RND_UP           = 2'd2,
        RND_TO_ZERO      = 2'd3
    } rnd_mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROUNDING_MODE  = 2'd0;
    localparam logic [1:0] CFG_TININESS_BEFORE = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_NAN    = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 2;

    // Biased single exponents that bound the half range
    localparam logic [7:0] EXP_HALF_NORM_MIN = 8'd113;  // 2^-14
    localparam logic [7:0] EXP_HALF_SUB_MIN  = 8'd103;  // 2^-24
    localparam logic [7:0] EXP_MASK_BASE     = 8'd102;
    localparam logic [8:0] EXP_IEEE_MAX      = 9'd142;  // 2^15
    localparam logic [8:0] EXP_ALT_MAX       = 9'd143;  // 2^16
    localparam logic [7:0] EXP_SPECIAL       = 8'hFF;

    localparam logic [15:0] HALF_DEFAULT_NAN = 16'h7E00;
    localparam logic [4:0]  HALF_EXP_ALL_ONE = 5'h1F;
    localparam logic [23:0] MASK_NORMAL      = 24'h001FFF;
    localparam logic [23:0] MASK_ALL         = 24'hFFFFFF;

    typedef struct packed {
        logic [31:0] single_value;
        logic        ieee_half_mode;
    } s2h_in_t;

    typedef struct packed {
        logic [15:0] half_value;
        logic        flag_invalid;
        logic        flag_overflow;
        logic        flag_underflow;
        logic        flag_inexact;
    } s2h_out_t;

    typedef struct packed {
        rnd_mode_t rounding_mode;
        logic      tininess_before_round;
        logic      default_nan_enable;
    } s2h_cfg_t;

endpackage

/* hw/rtl/s2h_convert.sv */
module s2h_convert
    import s2h_pkg::*;
(
    input  s2h_in_t  word_in,
    input  s2h_cfg_t cfg,
    output s2h_out_t word_out
);

    logic        sign;
    logic [7:0]  efield;
    logic [22:0] frac;
    logic [23:0] sig;
    logic [23:0] mask;
    logic [23:0] half_ulp;
    logic        lost;
    logic [24:0] inc;
    logic [24:0] sum;
    logic [23:0] sig_r;
    logic [8:0]  exp_r;
    logic [3:0]  mask_sh;
    logic [3:0]  den_sh;
    logic [23:0] sig_d;
    logic [4:0]  exp_out;
    logic [15:0] packed_half;

    assign sign   = word_in.single_value[31];
    assign efield = word_in.single_value[30:23];
    assign frac   = word_in.single_value[22:0];
    assign sig    = {1'b1, frac};

    // Mask of the bits dropped by the half precision at this exponent
    always_comb
    begin
        mask_sh = 4'(efield - EXP_MASK_BASE);
        if (efield >= EXP_HALF_NORM_MIN)
        begin
            mask = MASK_NORMAL;
        end
        else if (efield >= EXP_HALF_SUB_MIN)
        begin
            mask = MASK_ALL >> mask_sh;
        end
        else
        begin
            mask = MASK_ALL;
        end
    end

    assign half_ulp = mask ^ (mask >> 1);
    assign lost     = |(sig & mask);

    always_comb
    begin
        inc = '0;
        if (lost)
        begin
            unique case (cfg.rounding_mode)
                RND_NEAREST_EVEN:
                begin
                    if ((sig & mask) == half_ulp)
                        inc = {1'b0, sig} & {half_ulp, 1'b0};
                    else
                        inc = {1'b0, half_ulp};
                end
                RND_DOWN:    inc = sign ? {1'b0, mask} : '0;
                RND_UP:      inc = sign ? '0 : {1'b0, mask};
                RND_TO_ZERO: inc = '0;
                default:     inc = '0;
            endcase
        end
    end

    // Carry out of the significand bumps the exponent
    assign sum   = {1'b0, sig} + inc;
    assign sig_r = sum[24] ? sum[24:1] : sum[23:0];
    assign exp_r = {1'b0, efield} + {8'd0, sum[24]};

    assign den_sh = 4'({1'b0, EXP_HALF_NORM_MIN} - exp_r);

    always_comb
    begin
        if (exp_r < {1'b0, EXP_HALF_NORM_MIN})
        begin
            sig_d   = sig_r >> den_sh;
            exp_out = '0;
        end
        else
        begin
            sig_d   = sig_r;
            exp_out = 5'(exp_r - {1'b0, EXP_HALF_NORM_MIN});
        end
    end

    // Hidden bit adds into the exponent field
    assign packed_half = {sign, 15'd0} + {1'b0, exp_out, 10'd0} + {5'd0, sig_d[23:13]};

    always_comb
    begin
        word_out = '0;
        if (efield == EXP_SPECIAL)
        begin
            if (frac != '0)
            begin
                word_out.flag_invalid = ~frac[22];
                if (!word_in.ieee_half_mode)
                    word_out.half_value = {sign, 15'd0};
                else if (cfg.default_nan_enable || frac[22:13] == '0)
                    word_out.half_value = HALF_DEFAULT_NAN;
                else
                    word_out.half_value = {sign, HALF_EXP_ALL_ONE, frac[22:13]};
            end
            else if (!word_in.ieee_half_mode)
            begin
                word_out.flag_invalid = 1'b1;
                word_out.half_value   = {sign, 15'h7FFF};
            end
            else
            begin
                word_out.half_value = {sign, HALF_EXP_ALL_ONE, 10'd0};
            end
        end
        else if (efield == '0 && frac == '0)
        begin
            word_out.half_value = {sign, 15'd0};
        end
        else
        begin
            word_out.flag_underflow = lost ||
                (efield < EXP_HALF_NORM_MIN && cfg.tininess_before_round);
            if (word_in.ieee_half_mode && exp_r > EXP_IEEE_MAX)
            begin
                word_out.flag_overflow = 1'b1;
                word_out.flag_inexact  = 1'b1;
                word_out.half_value    = {sign, HALF_EXP_ALL_ONE, 10'd0};
            end
            else if (!word_in.ieee_half_mode && exp_r > EXP_ALT_MAX)
            begin
                word_out.flag_invalid = 1'b1;
                word_out.flag_inexact = 1'b1;
                word_out.half_value   = {sign, 15'h7FFF};
            end
            else if (exp_r < {1'b0, EXP_HALF_SUB_MIN})
            begin
                word_out.half_value = {sign, 15'd0};
            end
            else
            begin
                word_out.half_value = packed_half;
            end
        end
    end

endmodule

/* hw/rtl/single_to_half_convert.sv */
// Single to half precision converter.
// Input channel (in_valid/in_ready/in_data) carries one word: a single
// precision bit pattern and the target format select (IEEE half, or the
// alternative half with no Inf/NaN codes). Output channel
// (out_valid/out_ready/out_data) returns one word per input: the half
// pattern and the invalid, overflow, underflow and inexact flags.
// Rounding mode, tininess detection and default NaN come from the write
// port (cfg_we/cfg_index/cfg_data); write them only while the block is idle.
// The accepted word enters the input register at the accepting edge, passes
// the conversion logic, and lands in the result register, which drives
// out_valid. Throughput is one word per cycle while the receiver does not
// stall; the single conversion pass between the two registers sets it.
// When the receiver stalls, the result register holds its word and the
// input register fills behind it, so up to two words are buffered before
// in_ready drops.
// Reset clears both valid bits and all configuration registers
// (round to nearest even, tininess after rounding, default NaN off).
module single_to_half_convert
    import s2h_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  s2h_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output s2h_out_t               out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    s2h_cfg_t cfg_reg;
    s2h_cfg_t cfg_next;

    logic     in_valid_reg;
    s2h_in_t  in_data_reg;
    logic     out_valid_reg;
    s2h_out_t out_data_reg;
    s2h_out_t conv_word;
    logic     out_free;

    // Configuration registers: decode the index, drop writes past the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROUNDING_MODE:   cfg_next.rounding_mode = rnd_mode_t'(cfg_data);
                CFG_TININESS_BEFORE: cfg_next.tininess_before_round = cfg_data[0];
                CFG_DEFAULT_NAN:     cfg_next.default_nan_enable = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{RND_NEAREST_EVEN, 1'b0, 1'b0};
        else
            cfg_reg <= cfg_next;
    end

    // Advance the result register whenever it is empty or being taken;
    // advance the input register whenever its word can move on.
    assign out_free = ~out_valid_reg | out_ready;
    assign in_ready = ~in_valid_reg | out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (out_free && in_valid_reg)
            out_data_reg <= conv_word;
    end

    s2h_convert u_convert (
        .word_in  (in_data_reg),
        .cfg      (cfg_reg),
        .word_out (conv_word)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
